/* hw/rtl/gif_lzw_decoder_core_assert.svh */
// assertion macros used by the checker file of the gif lzw decoder
// depends on nothing; the including module provides clk_i and rst_ni
`ifndef GIF_LZW_DECODER_CORE_ASSERT_SVH
`define GIF_LZW_DECODER_CORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define GLZW_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("glzw assertion failed");

// implication checked on the following clock edge
`define GLZW_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("glzw assertion failed");

`endif

/* hw/rtl/glzw_pkg.sv */
// shared types and constants of the gif lzw decoder
// no dependencies
`default_nettype none

package glzw_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned BufW  = 24;
  localparam int unsigned HeldW = 5;
  localparam int unsigned CfgW  = 4;

  localparam logic [CfgW-1:0]  MinSizeLo  = 4'd2;
  localparam logic [CfgW-1:0]  MinSizeHi  = 4'd8;
  localparam logic [CfgW-1:0]  MinSizeRst = 4'd8;
  localparam logic [HeldW-1:0] PushLimit  = 5'd16;
  localparam logic [HeldW-1:0] ByteBits   = 5'd8;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_PULL  = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_NEED    = 3'd1,
    ST_CLEAR   = 3'd2,
    ST_END     = 3'd3,
    ST_BAD     = 3'd4,
    ST_TAKEN   = 3'd5,
    ST_REFUSED = 3'd6,
    ST_RESTART = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    CK_CLEAR,
    CK_EOI,
    CK_WALK,
    CK_KWKWK,
    CK_BAD
  } code_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_DECODE,
    S_WALK,
    S_WALK_WAIT,
    S_UPDATE,
    S_POP_WAIT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [DataW-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] pixel_index;
    logic [2:0]       status;
  } out_item_t;

  typedef struct packed {
    logic    load_in;
    logic    do_push;
    logic    do_restart;
    logic    take_code;
    logic    init_table;
    logic    set_done;
    logic    walk_from_code;
    logic    walk_from_prior;
    logic    walk_read;
    logic    walk_step;
    logic    walk_end;
    logic    update;
    logic    pop;
    logic    set_res;
    logic    res_from_stack;
    status_e res_status;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       push_ok;
    logic       stack_empty;
    logic       image_done;
    logic       enough_bits;
    code_kind_e kind;
    logic       walk_more;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/glzw_ctrl.sv */
// sequencing state machine of the gif lzw decoder
// depends on glzw_pkg; drives glzw_dpath through cmd_t
`default_nettype none

module glzw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  glzw_pkg::stat_t    stat_i,
  output glzw_pkg::cmd_t     cmd_o
);

  glzw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glzw_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == glzw_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      glzw_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = glzw_pkg::S_DISPATCH;
        end
      end
      glzw_pkg::S_DISPATCH: begin
        state_d       = glzw_pkg::S_FINISH;
        cmd_o.set_res = 1'b1;
        priority if (stat_i.op == glzw_pkg::OP_PUSH) begin
          if (stat_i.push_ok) begin
            cmd_o.do_push    = 1'b1;
            cmd_o.res_status = glzw_pkg::ST_TAKEN;
          end else begin
            cmd_o.res_status = glzw_pkg::ST_REFUSED;
          end
        end else if (stat_i.op == glzw_pkg::OP_PULL) begin
          priority if (!stat_i.stack_empty) begin
            cmd_o.set_res = 1'b0;
            cmd_o.pop     = 1'b1;
            state_d       = glzw_pkg::S_POP_WAIT;
          end else if (stat_i.image_done) begin
            cmd_o.res_status = glzw_pkg::ST_END;
          end else if (!stat_i.enough_bits) begin
            cmd_o.res_status = glzw_pkg::ST_NEED;
          end else begin
            cmd_o.set_res   = 1'b0;
            cmd_o.take_code = 1'b1;
            state_d         = glzw_pkg::S_DECODE;
          end
        end else if (stat_i.op == glzw_pkg::OP_START) begin
          cmd_o.do_restart = 1'b1;
          cmd_o.res_status = glzw_pkg::ST_RESTART;
        end else begin
          cmd_o.res_status = glzw_pkg::ST_REFUSED;
        end
      end
      glzw_pkg::S_DECODE: begin
        unique case (stat_i.kind)
          glzw_pkg::CK_CLEAR: begin
            cmd_o.init_table = 1'b1;
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = glzw_pkg::ST_CLEAR;
            state_d          = glzw_pkg::S_FINISH;
          end
          glzw_pkg::CK_EOI: begin
            cmd_o.set_done   = 1'b1;
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = glzw_pkg::ST_END;
            state_d          = glzw_pkg::S_FINISH;
          end
          glzw_pkg::CK_WALK: begin
            cmd_o.walk_from_code = 1'b1;
            state_d              = glzw_pkg::S_WALK;
          end
          glzw_pkg::CK_KWKWK: begin
            cmd_o.walk_from_prior = 1'b1;
            state_d               = glzw_pkg::S_WALK;
          end
          default: begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = glzw_pkg::ST_BAD;
            state_d          = glzw_pkg::S_FINISH;
          end
        endcase
      end
      glzw_pkg::S_WALK: begin
        if (stat_i.walk_more) begin
          cmd_o.walk_read = 1'b1;
          state_d         = glzw_pkg::S_WALK_WAIT;
        end else begin
          cmd_o.walk_end = 1'b1;
          state_d        = glzw_pkg::S_UPDATE;
        end
      end
      glzw_pkg::S_WALK_WAIT: begin
        cmd_o.walk_step = 1'b1;
        state_d         = glzw_pkg::S_WALK;
      end
      glzw_pkg::S_UPDATE: begin
        cmd_o.update = 1'b1;
        cmd_o.pop    = 1'b1;
        state_d      = glzw_pkg::S_POP_WAIT;
      end
      glzw_pkg::S_POP_WAIT: begin
        cmd_o.set_res        = 1'b1;
        cmd_o.res_from_stack = 1'b1;
        cmd_o.res_status     = glzw_pkg::ST_PIXEL;
        state_d              = glzw_pkg::S_FINISH;
      end
      glzw_pkg::S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = glzw_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = glzw_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/glzw_dpath.sv */
// datapath of the gif lzw decoder: bit buffer, string table, expansion stack
// depends on glzw_pkg; commanded by glzw_ctrl
`default_nettype none

module glzw_dpath #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [glzw_pkg::CfgW-1:0]   min_code_size_i,
  input  glzw_pkg::in_item_t               in_data_i,
  output glzw_pkg::out_item_t              out_data_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  input  glzw_pkg::cmd_t                   cmd_i,
  output glzw_pkg::stat_t                  stat_o
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned VW = ((MAX_CODE_BITS > AW) ? MAX_CODE_BITS : AW) + 1;
  localparam int unsigned DW = AW + 1;
  localparam logic [VW-1:0] TabEnd  = VW'(TABLE_ENTRIES);
  localparam logic [DW-1:0] StkEnd  = DW'(TABLE_ENTRIES);
  localparam logic [3:0]    MaxBits = 4'(MAX_CODE_BITS);
  localparam logic [VW-1:0] RstClr  = VW'(1) << glzw_pkg::MinSizeRst;

  // memories
  logic [AW-1:0]                 prefix_mem [TABLE_ENTRIES];
  logic [glzw_pkg::DataW-1:0]    suffix_mem [TABLE_ENTRIES];
  logic [glzw_pkg::DataW-1:0]    stack_mem  [TABLE_ENTRIES];
  logic [AW-1:0]                 prefix_rq;
  logic [glzw_pkg::DataW-1:0]    suffix_rq;
  logic [glzw_pkg::DataW-1:0]    stk_rdata_q;

  logic [glzw_pkg::BufW-1:0]     buf_q, buf_d;
  logic [glzw_pkg::HeldW-1:0]    held_q, held_d;
  logic [DW-1:0]                 depth_q, depth_d;
  logic [VW-1:0]                 nfc_q, nfc_d;
  logic [3:0]                    cw_q, cw_d;
  logic [VW-1:0]                 prior_q, prior_d;
  logic [glzw_pkg::DataW-1:0]    pfc_q, pfc_d;
  logic                          done_q, done_d;
  logic [VW-1:0]                 code_q, walk_q;
  logic [glzw_pkg::DataW-1:0]    first_q;
  glzw_pkg::in_item_t            item_q;
  logic [2:0]                    res_status_q;
  logic [glzw_pkg::DataW-1:0]    res_pix_q;
  glzw_pkg::out_item_t           out_q;
  logic                          out_valid_q;

  logic [3:0]                    eff_size;
  logic [VW-1:0]                 clr, eoi, first_entry, nfc_inc;
  logic [MAX_CODE_BITS-1:0]      code_mask;
  logic                          stk_push, stk_we, tab_we;
  logic [glzw_pkg::DataW-1:0]    stk_wdata;
  logic [AW-1:0]                 pop_addr;

  always_comb begin
    priority if (min_code_size_i < glzw_pkg::MinSizeLo) begin
      eff_size = glzw_pkg::MinSizeLo;
    end else if (min_code_size_i > glzw_pkg::MinSizeHi) begin
      eff_size = glzw_pkg::MinSizeHi;
    end else begin
      eff_size = min_code_size_i;
    end
  end

  assign clr         = VW'(1) << eff_size;
  assign eoi         = clr + VW'(1);
  assign first_entry = clr + VW'(2);
  assign nfc_inc     = nfc_q + VW'(1);
  assign code_mask   = (MAX_CODE_BITS'(1) << cw_q) - MAX_CODE_BITS'(1);
  assign pop_addr    = AW'(depth_q - DW'(1));

  // status toward the controller
  always_comb begin
    stat_o.op          = item_q.op;
    stat_o.push_ok     = (held_q <= glzw_pkg::PushLimit);
    stat_o.stack_empty = (depth_q == '0);
    stat_o.image_done  = done_q;
    stat_o.enough_bits = (held_q >= {1'b0, cw_q});
    stat_o.walk_more   = (walk_q >= first_entry) && (walk_q < TabEnd);
    stat_o.out_free    = !out_valid_q || out_ready_i;
    priority if (code_q == clr) begin
      stat_o.kind = glzw_pkg::CK_CLEAR;
    end else if (code_q == eoi) begin
      stat_o.kind = glzw_pkg::CK_EOI;
    end else if (prior_q == clr) begin
      stat_o.kind = (code_q > clr) ? glzw_pkg::CK_BAD : glzw_pkg::CK_WALK;
    end else if (code_q < nfc_q) begin
      stat_o.kind = glzw_pkg::CK_WALK;
    end else if ((code_q == nfc_q) && (nfc_q < TabEnd)) begin
      stat_o.kind = glzw_pkg::CK_KWKWK;
    end else begin
      stat_o.kind = glzw_pkg::CK_BAD;
    end
  end

  // stack push source
  always_comb begin
    stk_push  = cmd_i.walk_from_prior || cmd_i.walk_step || cmd_i.walk_end;
    stk_wdata = walk_q[glzw_pkg::DataW-1:0];
    if (cmd_i.walk_from_prior) begin
      stk_wdata = pfc_q;
    end else if (cmd_i.walk_step) begin
      stk_wdata = suffix_rq;
    end
  end
  assign stk_we = stk_push && (depth_q < StkEnd);
  assign tab_we = cmd_i.update && (prior_q != clr) && (nfc_q < TabEnd);

  always_comb begin
    buf_d   = buf_q;
    held_d  = held_q;
    depth_d = depth_q;
    nfc_d   = nfc_q;
    cw_d    = cw_q;
    prior_d = prior_q;
    pfc_d   = pfc_q;
    done_d  = done_q;
    if (cmd_i.do_push) begin
      buf_d  = buf_q | (glzw_pkg::BufW'(item_q.data_byte) << held_q);
      held_d = held_q + glzw_pkg::ByteBits;
    end
    if (cmd_i.take_code) begin
      buf_d  = buf_q >> cw_q;
      held_d = held_q - {1'b0, cw_q};
    end
    if (cmd_i.do_restart) begin
      buf_d  = '0;
      held_d = '0;
      depth_d = '0;
      pfc_d  = '0;
      done_d = 1'b0;
    end
    if (cmd_i.do_restart || cmd_i.init_table) begin
      nfc_d   = first_entry;
      cw_d    = eff_size + 4'd1;
      prior_d = clr;
    end
    if (cmd_i.set_done) begin
      done_d = 1'b1;
    end
    if (stk_we) begin
      depth_d = depth_q + DW'(1);
    end
    if (cmd_i.pop) begin
      depth_d = depth_q - DW'(1);
    end
    if (cmd_i.update) begin
      if (tab_we) begin
        nfc_d = nfc_inc;
        if ((nfc_inc == (VW'(1) << cw_q)) && (cw_q < MaxBits)) begin
          cw_d = cw_q + 4'd1;
        end
      end
      prior_d = code_q;
      pfc_d   = first_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      held_q      <= '0;
      depth_q     <= '0;
      nfc_q       <= RstClr + VW'(2);
      cw_q        <= glzw_pkg::MinSizeRst + 4'd1;
      prior_q     <= RstClr;
      pfc_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q   <= buf_d;
      held_q  <= held_d;
      depth_q <= depth_d;
      nfc_q   <= nfc_d;
      cw_q    <= cw_d;
      prior_q <= prior_d;
      pfc_q   <= pfc_d;
      done_q  <= done_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      item_q <= in_data_i;
    end
    if (cmd_i.take_code) begin
      code_q <= VW'(buf_q[MAX_CODE_BITS-1:0] & code_mask);
    end
    if (cmd_i.walk_from_code) begin
      walk_q <= code_q;
    end else if (cmd_i.walk_from_prior) begin
      walk_q <= prior_q;
    end else if (cmd_i.walk_step) begin
      walk_q <= VW'(prefix_rq);
    end
    if (cmd_i.walk_end) begin
      first_q <= walk_q[glzw_pkg::DataW-1:0];
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_pix_q    <= cmd_i.res_from_stack ? stk_rdata_q : '0;
    end
    if (cmd_i.load_out) begin
      out_q.pixel_index <= res_pix_q;
      out_q.status      <= res_status_q;
    end
  end

  // string table
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      prefix_mem[nfc_q[AW-1:0]] <= prior_q[AW-1:0];
      suffix_mem[nfc_q[AW-1:0]] <= first_q;
    end
    if (cmd_i.walk_read) begin
      prefix_rq <= prefix_mem[walk_q[AW-1:0]];
      suffix_rq <= suffix_mem[walk_q[AW-1:0]];
    end
  end

  // expansion stack
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[depth_q[AW-1:0]] <= stk_wdata;
    end
    if (cmd_i.pop) begin
      stk_rdata_q <= stack_mem[pop_addr];
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/gif_lzw_decoder_core.sv */
// top level of the gif lzw decoder: config register, controller, datapath
// depends on glzw_pkg, glzw_ctrl, glzw_dpath
//
// channel   direction  handshake                payload
// in        input      in_valid_i / in_ready_o  in_data_i   (op, data_byte)
// out       output     out_valid_o / out_ready_i out_data_o (pixel_index, status)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (min_code_size)
//
// push, start, unused op and answers without a code pass dispatch, then finish
// a pull that pops a waiting pixel also passes a pop wait for the stack read port
// a pull that reads a data code walks its chain with one table read per step
// reset clears all control state; the string table and stack need no clearing
// a stalled output holds its transaction while the next input is taken
`default_nettype none

module gif_lzw_decoder_core #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  glzw_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output glzw_pkg::out_item_t             out_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [glzw_pkg::CfgW-1:0]  cfg_data_i
);

  // configuration register, to be written only between images; the block does not enforce it
  logic [glzw_pkg::CfgW-1:0] min_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= glzw_pkg::MinSizeRst;
    end else if (cfg_valid_i) begin
      min_size_q <= cfg_data_i;
    end
  end

  // the config port never stalls a transaction
  assign cfg_ready_o = 1'b1;

  glzw_pkg::cmd_t  cmd;
  glzw_pkg::stat_t stat;

  // state machine picks the step, datapath does the work
  glzw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  glzw_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .min_code_size_i (min_size_q),
    .in_data_i       (in_data_i),
    .out_data_o      (out_data_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule

`default_nettype wire

/* hw/rtl/glzw_checker.sv */
// port-level checker of the gif lzw decoder, bound to the top level
// depends on glzw_pkg and gif_lzw_decoder_core_assert.svh
`default_nettype none

`include "gif_lzw_decoder_core_assert.svh"

module glzw_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input glzw_pkg::in_item_t             in_data_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input glzw_pkg::out_item_t            out_data_o,
  input wire logic                      cfg_valid_i,
  input wire logic                      cfg_ready_o,
  input wire logic [glzw_pkg::CfgW-1:0] cfg_data_i
);

  // a stalled result stays offered
  `GLZW_ASSERT_NEXT(out_hold_a, out_valid_o && !out_ready_i, out_valid_o)
  // a stalled result keeps its payload
  `GLZW_ASSERT_NEXT(out_stable_a, out_valid_o && !out_ready_i, $stable(out_data_o))
  // only a pixel result carries a palette index
  `GLZW_ASSERT(pix_zero_a, (out_valid_o && (out_data_o.status != glzw_pkg::ST_PIXEL)) |-> (out_data_o.pixel_index == '0))
  // one transaction at a time: input closes right after an accept
  `GLZW_ASSERT_NEXT(one_item_a, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind gif_lzw_decoder_core glzw_checker u_chk (.*);

`default_nettype wire
